/* rtl/smc_pkg.sv */
// Shared types and constants for the substring match counter.
// Holds the transfer payload structs, the register index codes and the default sizes.
// No dependencies.
package smc_pkg;

    localparam int TEXT_BYTE_W     = 8;
    localparam int POS_W           = 17;
    localparam int IDX_W           = 16;
    localparam int TOTAL_W         = 17;
    localparam int LEN_REG_W       = 5;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_INDEX_W     = 2;
    localparam int PAT_BYTES       = 16;
    localparam int PAT_IDX_W       = 4;
    localparam int PAT_W           = PAT_BYTES * TEXT_BYTE_W;
    localparam int PATTERN_MAX_DEF = 16;
    localparam int TEXT_MAX_DEF    = 65536;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_LENGTH = 2'd0,
        CFG_PATTERN_LOW    = 2'd1,
        CFG_PATTERN_HIGH   = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [TEXT_BYTE_W-1:0] text_byte;
        logic                   final_byte;
    } in_item_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] match_total;
        logic [IDX_W-1:0]   first_start;
        logic [IDX_W-1:0]   last_start;
        logic               found;
        logic               too_long;
    } out_item_t;

    // Per-cycle control from the input stage to the search logic.
    typedef struct packed {
        logic step;   // the held byte is processed this cycle
        logic last;   // the held byte ends the text
    } step_ctrl_t;

endpackage

/* rtl/smc_cfg_regs.sv */
// Pattern configuration registers and the clamped effective pattern length.
// Depends on smc_pkg.
module smc_cfg_regs
    import smc_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic [PAT_W-1:0]      pattern,
    output logic [LEN_W-1:0]      len_eff
);

    logic [LEN_REG_W-1:0]  pattern_length_reg;
    logic [CFG_DATA_W-1:0] pattern_low_reg;
    logic [CFG_DATA_W-1:0] pattern_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= LEN_REG_W'(1);
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[LEN_REG_W-1:0];
                CFG_PATTERN_LOW:    pattern_low_reg    <= cfg_data;
                CFG_PATTERN_HIGH:   pattern_high_reg   <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign pattern = {pattern_high_reg, pattern_low_reg};

    // Lengths beyond the window depth act as the full window.
    always_comb
    begin
        if (pattern_length_reg > LEN_REG_W'(PATTERN_MAX))
            len_eff = LEN_W'(PATTERN_MAX);
        else
            len_eff = LEN_W'(pattern_length_reg);
    end

endmodule

/* rtl/smc_match.sv */
// Window of the newest text bytes and the parallel compare against the pattern.
// Depends on smc_pkg.
module smc_match
    import smc_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
)
(
    input  logic                   clk,
    input  step_ctrl_t             ctrl,
    input  logic [TEXT_BYTE_W-1:0] text_byte,
    input  logic [PAT_W-1:0]       pattern,
    input  logic [LEN_W-1:0]       len_eff,
    output logic                   hit
);

    logic [TEXT_BYTE_W-1:0] window_reg  [PATTERN_MAX];
    logic [TEXT_BYTE_W-1:0] window_next [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] byte_ok;

    // Entry 0 is the newest byte; the compare looks at the window after the shift.
    always_comb
    begin
        window_next[0] = text_byte;
        for (int i = 1; i < PATTERN_MAX; i++)
            window_next[i] = window_reg[i-1];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step)
            window_reg <= window_next;
    end

    // Window entry j pairs with pattern byte len-1-j; entries past the length are ignored.
    always_comb
    begin
        logic [PAT_IDX_W-1:0] pidx;
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            pidx = PAT_IDX_W'(LEN_REG_W'(len_eff) - LEN_REG_W'(1) - LEN_REG_W'(j));
            if (LEN_REG_W'(j) < LEN_REG_W'(len_eff))
                byte_ok[j] = (pattern[pidx*TEXT_BYTE_W +: TEXT_BYTE_W] == window_next[j]);
            else
                byte_ok[j] = 1'b1;
        end
    end

    assign hit = (len_eff != '0) && (&byte_ok);

endmodule

/* rtl/smc_tally.sv */
// Match bookkeeping per text and the result register.
// Depends on smc_pkg.
module smc_tally
    import smc_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int TEXT_MAX    = TEXT_MAX_DEF,
    parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  step_ctrl_t       ctrl,
    input  logic             hit,
    input  logic [LEN_W-1:0] len_eff,
    input  logic             out_ready,
    output logic             out_valid,
    output out_item_t        out_item
);

    logic [POS_W-1:0]   position_reg,   position_next;
    logic [POS_W-1:0]   allowed_reg,    allowed_next;
    logic [TOTAL_W-1:0] total_reg,      total_next;
    logic [IDX_W-1:0]   first_reg,      first_next;
    logic [IDX_W-1:0]   last_reg,       last_next;
    logic               any_reg,        any_next;
    logic               overflow_reg,   overflow_next;
    logic               out_valid_reg,  out_valid_next;
    out_item_t          out_item_reg,   out_item_next;

    logic [POS_W-1:0] pos_inc;
    logic [POS_W-1:0] start;
    logic             take;

    assign pos_inc = position_reg + POS_W'(1);
    assign start   = pos_inc - POS_W'(len_eff);
    // A match counts only once enough bytes arrived and it clears the previous match.
    assign take    = hit && (pos_inc >= POS_W'(len_eff)) && (start >= allowed_reg);

    always_comb
    begin
        position_next = position_reg;
        allowed_next  = allowed_reg;
        total_next    = total_reg;
        first_next    = first_reg;
        last_next     = last_reg;
        any_next      = any_reg;
        overflow_next = overflow_reg;
        out_item_next = out_item_reg;

        if (position_reg >= POS_W'(TEXT_MAX))
        begin
            overflow_next = 1'b1;
        end
        else
        begin
            if (take)
            begin
                if (!any_reg)
                    first_next = start[IDX_W-1:0];
                last_next    = start[IDX_W-1:0];
                any_next     = 1'b1;
                total_next   = total_reg + TOTAL_W'(1);
                allowed_next = pos_inc;
            end
            position_next = pos_inc;
        end

        out_item_next.match_total = total_next;
        out_item_next.first_start = any_next ? first_next : '0;
        out_item_next.last_start  = any_next ? last_next  : '0;
        out_item_next.found       = any_next;
        out_item_next.too_long    = overflow_next;

        if (ctrl.step && ctrl.last)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg  <= '0;
            allowed_reg   <= '0;
            total_reg     <= '0;
            first_reg     <= '0;
            last_reg      <= '0;
            any_reg       <= 1'b0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (ctrl.step)
            begin
                if (ctrl.last)
                begin
                    position_reg <= '0;
                    allowed_reg  <= '0;
                    total_reg    <= '0;
                    first_reg    <= '0;
                    last_reg     <= '0;
                    any_reg      <= 1'b0;
                    overflow_reg <= 1'b0;
                end
                else
                begin
                    position_reg <= position_next;
                    allowed_reg  <= allowed_next;
                    total_reg    <= total_next;
                    first_reg    <= first_next;
                    last_reg     <= last_next;
                    any_reg      <= any_next;
                    overflow_reg <= overflow_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step && ctrl.last)
            out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

/* rtl/substring_match_counter.sv */
// Top level of the substring match counter: input register, window compare and tally.
// Depends on smc_pkg, smc_cfg_regs, smc_match and smc_tally.
//
// The block takes a text one byte per transfer on the input channel and counts the
// leftmost, non-overlapping occurrences of a pattern of 1 to PATTERN_MAX bytes that is
// set through the register port (length, then bytes 0 to 7 and 8 to 15 in two 64-bit
// words, byte 0 in the low bits). After a counted match the search resumes past its
// end. The transfer that carries the final_byte mark closes the text and produces one
// result transfer with the count, the start indexes of the first and of the last
// counted match, a found flag and a too_long flag for texts longer than TEXT_MAX bytes;
// the per-text state then clears, while the pattern registers keep their values.
// A byte is accepted in every cycle unless a final byte waits: each byte is held in
// the input register, where the whole window is compared against the pattern in
// parallel and the counters are updated in the same cycle, so the sustained rate is one
// byte per clock while no final byte waits. A result reaches the output register in the
// cycle after the final byte is processed and stays there until it is taken.
// Only a final byte can wait: it stays in the input register while an earlier result
// has not yet been taken, and a fresh byte is still accepted in the cycle that the
// waiting result leaves. Lengths above PATTERN_MAX act as PATTERN_MAX and a length of
// zero never matches. The user must write the registers only while no text is in
// flight; the block itself does not enforce it.
module substring_match_counter
    import smc_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int TEXT_MAX    = TEXT_MAX_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_item_t               in_item,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_item_t              out_item,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    logic             s1_valid_reg, s1_valid_next;
    in_item_t         s1_item_reg;
    step_ctrl_t       ctrl;
    logic             in_take;
    logic             hit;
    logic [PAT_W-1:0] pattern;
    logic [LEN_W-1:0] len_eff;

    // The held byte is processed unless it closes a text while the previous result is
    // still waiting in the output register.
    assign ctrl.step = s1_valid_reg && !(s1_item_reg.final_byte && out_valid && !out_ready);
    assign ctrl.last = s1_item_reg.final_byte;

    assign in_ready = !s1_valid_reg || ctrl.step;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        if (in_take)
            s1_valid_next = 1'b1;
        else if (ctrl.step)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_item_reg <= in_item;
    end

    smc_cfg_regs #(
        .PATTERN_MAX (PATTERN_MAX),
        .LEN_W       (LEN_W)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pattern   (pattern),
        .len_eff   (len_eff)
    );

    smc_match #(
        .PATTERN_MAX (PATTERN_MAX),
        .LEN_W       (LEN_W)
    ) u_match (
        .clk       (clk),
        .ctrl      (ctrl),
        .text_byte (s1_item_reg.text_byte),
        .pattern   (pattern),
        .len_eff   (len_eff),
        .hit       (hit)
    );

    smc_tally #(
        .PATTERN_MAX (PATTERN_MAX),
        .TEXT_MAX    (TEXT_MAX),
        .LEN_W       (LEN_W)
    ) u_tally (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .hit       (hit),
        .len_eff   (len_eff),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

`ifndef SYNTHESIS
    // A result without a match carries no count and no indexes.
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_item.found) |->
            (out_item.match_total == '0 && out_item.first_start == '0
             && out_item.last_start == '0))
        else $error("result without a match carries nonzero fields");

    // A found result counts at least one match and the last match never precedes the first.
    a_found_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.found) |->
            (out_item.match_total != '0 && out_item.last_start >= out_item.first_start))
        else $error("found result with inconsistent count or indexes");

    // A final byte held back by a waiting result stays in the input register.
    a_final_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_item_reg.final_byte && out_valid && !out_ready)
            |=> (s1_valid_reg && s1_item_reg.final_byte))
        else $error("stalled final byte was lost");
`endif

endmodule
